// File: src/tlik_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths, constants and tables of the two-link inverse kinematics core.
package tlik_pkg;

  // Serial multiplier: multiplicand, multiplier and product widths
  localparam int MUL_AW = 34;
  localparam int MUL_BW = 20;
  localparam int MUL_PW = 54;

  // Bit-pair square root
  localparam int SQ_W  = 36;
  localparam int SQ_RW = 19;

  // Restoring divider
  localparam int DIV_NW = 48;
  localparam int DIV_DW = 34;
  localparam int DIV_QW = 15;

  // Vectoring CORDIC
  localparam int COR_IW   = 16;
  localparam int COR_W    = 34;
  localparam int COR_ZW   = 24;
  localparam int COR_OW   = 18;
  localparam int COR_MAXN = 24;
  localparam int COR_IDXW = 5;
  localparam int HALF_PI_Q20 = 1647099;

  localparam int ANGLE_WIDTH_DEF  = 20;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic [12:0] L1_RESET = 13'd2432;
  localparam logic [12:0] L2_RESET = 13'd2560;

  // 1.0 squared in Q.28
  localparam logic [28:0] ONE_SQ_Q28 = 29'h1000_0000;

  // Radians Q.14 to degrees: (mag*1260 + 11*2^14) / (22*2^14)
  localparam int DEG_MUL  = 1260;
  localparam int DEG_HALF = 180224;
  localparam int DEG_DIV  = 360448;
  localparam longint DEG_SAT = 64'd369098752;  // 1024 * DEG_DIV

  typedef enum logic [0:0] {
    REG_L1 = 1'b0,
    REG_L2 = 1'b1
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_MXX, S_MYY, S_ML1, S_ML2, S_SQR, S_MD1, S_MD2, S_CHK,
    S_DV1, S_DV2, S_MC1, S_SQ1, S_CO1, S_MC2, S_SQ2, S_CO2, S_CO0,
    S_ANG, S_MG1, S_DG1, S_MG2, S_DG2, S_DONE
  } state_t;

  // Arctangent of 2^-i in Q.20
  function automatic logic [20:0] atan_q20(input logic [COR_IDXW-1:0] i);
    logic [20:0] v;
    unique case (i)
      5'd0:  v = 21'd823550;
      5'd1:  v = 21'd486170;
      5'd2:  v = 21'd256879;
      5'd3:  v = 21'd130396;
      5'd4:  v = 21'd65451;
      5'd5:  v = 21'd32757;
      5'd6:  v = 21'd16383;
      5'd7:  v = 21'd8192;
      5'd8:  v = 21'd4096;
      5'd9:  v = 21'd2048;
      5'd10: v = 21'd1024;
      5'd11: v = 21'd512;
      5'd12: v = 21'd256;
      5'd13: v = 21'd128;
      5'd14: v = 21'd64;
      5'd15: v = 21'd32;
      5'd16: v = 21'd16;
      5'd17: v = 21'd8;
      5'd18: v = 21'd4;
      5'd19: v = 21'd2;
      5'd20: v = 21'd1;
      default: v = 21'd0;
    endcase
    return v;
  endfunction

endpackage

// File: src/tlik_mul.sv
`timescale 1ns / 1ps
// Shift-and-add multiplier, one multiplier bit per cycle.
module tlik_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tlik_pkg::MUL_AW-1:0]   a_in,
  input  logic [tlik_pkg::MUL_BW-1:0]   b_in,
  output logic                          done,
  output logic [tlik_pkg::MUL_PW-1:0]   prod
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [tlik_pkg::MUL_PW-1:0]   acc_r, acc_nxt;
  logic [tlik_pkg::MUL_PW-1:0]   a_r, a_nxt;
  logic [tlik_pkg::MUL_BW-1:0]   b_r, b_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    if (start) begin
      busy_nxt = 1'b1;
      acc_nxt  = '0;
      a_nxt    = tlik_pkg::MUL_PW'(a_in);
      b_nxt    = b_in;
    end else if (busy_r) begin
      if (b_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (b_r[0]) acc_nxt = acc_r + a_r;
        a_nxt = a_r << 1;
        b_nxt = b_r >> 1;
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// File: src/tlik_sqrt.sv
`timescale 1ns / 1ps
// Integer square root, one result bit per cycle.
module tlik_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [tlik_pkg::SQ_W-1:0]    v_in,
  output logic                         done,
  output logic [tlik_pkg::SQ_RW-1:0]   root
);

  localparam int STEPS = tlik_pkg::SQ_W / 2;
  localparam int CW    = $clog2(STEPS + 1);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [tlik_pkg::SQ_W-1:0]   v_r, v_nxt;
  logic [tlik_pkg::SQ_W-1:0]   res_r, res_nxt;
  logic [tlik_pkg::SQ_W-1:0]   bit_r, bit_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [tlik_pkg::SQ_W-1:0]   trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
    cnt_r <= cnt_nxt;
  end

  assign trial = res_r + bit_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    v_nxt    = v_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      v_nxt    = v_in;
      res_nxt  = '0;
      bit_nxt  = tlik_pkg::SQ_W'(1) << (tlik_pkg::SQ_W - 2);
      cnt_nxt  = CW'(STEPS);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (v_r >= trial) begin
          v_nxt   = v_r - trial;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r - CW'(1);
      end
    end
  end

  assign done = done_r;
  assign root = res_r[tlik_pkg::SQ_RW-1:0];

endmodule

// File: src/tlik_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module tlik_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tlik_pkg::DIV_NW-1:0]   n_in,
  input  logic [tlik_pkg::DIV_DW-1:0]   d_in,
  output logic                          done,
  output logic [tlik_pkg::DIV_QW-1:0]   quot
);

  localparam int QW = tlik_pkg::DIV_QW;
  localparam int CW = $clog2(QW + 1);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [tlik_pkg::DIV_NW-1:0]   rem_r, rem_nxt;
  logic [tlik_pkg::DIV_NW-1:0]   ds_r, ds_nxt;
  logic [QW-1:0]                 q_r, q_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    ds_r  <= ds_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    ds_nxt   = ds_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      rem_nxt  = n_in;
      ds_nxt   = tlik_pkg::DIV_NW'(d_in) << (QW - 1);
      q_nxt    = '0;
      cnt_nxt  = CW'(QW);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (rem_r >= ds_r) begin
          rem_nxt = rem_r - ds_r;
          q_nxt   = {q_r[QW-2:0], 1'b1};
        end else begin
          q_nxt   = {q_r[QW-2:0], 1'b0};
        end
        ds_nxt  = ds_r >> 1;
        cnt_nxt = cnt_r - CW'(1);
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// File: src/tlik_cordic.sv
`timescale 1ns / 1ps
// Vectoring CORDIC for atan2, one micro-rotation per cycle.
module tlik_cordic #(
  parameter int CORDIC_STEPS = tlik_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [tlik_pkg::COR_IW-1:0]  y_in,
  input  logic signed [tlik_pkg::COR_IW-1:0]  x_in,
  output logic                                done,
  output logic signed [tlik_pkg::COR_OW-1:0]  ang
);

  localparam int W  = tlik_pkg::COR_W;
  localparam int ZW = tlik_pkg::COR_ZW;
  localparam int IW = tlik_pkg::COR_IDXW;
  localparam int NSTEPS = (CORDIC_STEPS > tlik_pkg::COR_MAXN) ? tlik_pkg::COR_MAXN
                                                               : CORDIC_STEPS;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic signed [W-1:0]  px_r, px_nxt;
  logic signed [W-1:0]  py_r, py_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic [IW-1:0]        i_r, i_nxt;
  logic signed [W-1:0]  xs, ys, sx, sy;
  logic signed [ZW-1:0] tab, zr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r <= px_nxt;
    py_r <= py_nxt;
    z_r  <= z_nxt;
    i_r  <= i_nxt;
  end

  assign xs  = W'(x_in) <<< 14;
  assign ys  = W'(y_in) <<< 14;
  assign sx  = px_r >>> i_r;
  assign sy  = py_r >>> i_r;
  assign tab = $signed(ZW'(tlik_pkg::atan_q20(i_r)));

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    px_nxt   = px_r;
    py_nxt   = py_r;
    z_nxt    = z_r;
    i_nxt    = i_r;
    if (start) begin
      busy_nxt = 1'b1;
      i_nxt    = '0;
      // pre-rotate a quarter turn for the left half-plane
      if (xs < 0) begin
        if (ys >= 0) begin
          px_nxt = ys;
          py_nxt = -xs;
          z_nxt  = ZW'(tlik_pkg::HALF_PI_Q20);
        end else begin
          px_nxt = -ys;
          py_nxt = xs;
          z_nxt  = -ZW'(tlik_pkg::HALF_PI_Q20);
        end
      end else begin
        px_nxt = xs;
        py_nxt = ys;
        z_nxt  = '0;
      end
    end else if (busy_r) begin
      if (i_r == IW'(NSTEPS)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (py_r >= 0) begin
          px_nxt = px_r + sy;
          py_nxt = py_r - sx;
          z_nxt  = z_r + tab;
        end else begin
          px_nxt = px_r - sy;
          py_nxt = py_r + sx;
          z_nxt  = z_r - tab;
        end
        i_nxt = i_r + IW'(1);
      end
    end
  end

  // round Q.20 to Q.14
  assign zr   = z_r + ZW'(32);
  assign ang  = zr[tlik_pkg::COR_OW+5:6];
  assign done = done_r;

endmodule

// File: src/two_link_inverse_kinematics_core.sv
`timescale 1ns / 1ps
// Top level of the two-link planar inverse kinematics core.
//
// Each request carries a target point (x,y) in 1/256 cm. The core finds the
// shoulder angle atan2(y,x) + acos((l1^2+r^2-l2^2)/(2*l1*r)) and the elbow
// angle -acos((r^2-l1^2-l2^2)/(2*l1*l2)) in Q.14 radians, and returns the
// change of each against the last reachable target in motor degrees
// (x 180*7/22, rounded half away from zero, saturated to -1024..1023). A
// target with r zero, a zero link length, or an acos argument beyond +/-1 is
// flagged unreachable with zero deltas and leaves the stored angles alone.
// One request is worked at a time by a sequencer driving four shared
// bit-serial units: a shift-add multiplier (it stops early when the rest of
// the multiplier is zero), the square root, the restoring divider and the
// CORDIC. The serial multiplier is used ten times for a reachable target. A
// new request is taken while the previous result still waits on the output
// register.
// Link lengths sit at byte addresses 0 and 4 and should only be written while
// the core is idle.
module two_link_inverse_kinematics_core #(
  parameter int ANGLE_WIDTH  = tlik_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = tlik_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [13:0] in_target_x,
  input  logic signed [13:0] in_target_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [10:0] out_shoulder_delta_deg,
  output logic signed [10:0] out_elbow_delta_deg,
  output logic               out_unreachable,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int AW = ANGLE_WIDTH;
  localparam int DW = AW + 1;
  localparam int SW = AW + 19;

  // Sequencer and configuration
  tlik_pkg::state_t state_r, state_nxt;
  logic             go_r;
  logic [12:0]      l1_r, l2_r;
  logic             out_valid_r, out_valid_nxt;
  logic signed [AW-1:0] last_sh_r, last_sh_nxt;
  logic signed [AW-1:0] last_el_r, last_el_nxt;

  // Working registers
  logic signed [13:0] x_r, x_nxt, y_r, y_nxt;
  logic [27:0]        r2_r, r2_nxt;
  logic [25:0]        l1sq_r, l1sq_nxt, l2sq_r, l2sq_nxt;
  logic [tlik_pkg::SQ_RW-1:0] r_r, r_nxt;
  logic [32:0]        den1_r, den1_nxt;
  logic [26:0]        den2_r, den2_nxt;
  logic [32:0]        mag1_r, mag1_nxt;
  logic [28:0]        mag2_r, mag2_nxt;
  logic               neg1_r, neg1_nxt, neg2_r, neg2_nxt;
  logic [14:0]        cm1_r, cm1_nxt, cm2_r, cm2_nxt;
  logic [14:0]        s_r, s_nxt;
  logic signed [17:0] acos1_r, acos1_nxt, acos2_r, acos2_nxt, atan_r, atan_nxt;
  logic signed [DW-1:0] dsh_r, dsh_nxt, del_r, del_nxt;
  logic signed [10:0] shdeg_r, shdeg_nxt, eldeg_r, eldeg_nxt;
  logic               unr_r, unr_nxt;
  logic signed [10:0] osh_r, osh_nxt, oel_r, oel_nxt;
  logic               ounr_r, ounr_nxt;

  // Shared units
  logic                              mul_start, mul_done;
  logic [tlik_pkg::MUL_AW-1:0]       mul_a;
  logic [tlik_pkg::MUL_BW-1:0]       mul_b;
  logic [tlik_pkg::MUL_PW-1:0]       mul_p;
  logic                              sq_start, sq_done;
  logic [tlik_pkg::SQ_W-1:0]         sq_v;
  logic [tlik_pkg::SQ_RW-1:0]        sq_root;
  logic                              div_start, div_done;
  logic [tlik_pkg::DIV_NW-1:0]       div_n;
  logic [tlik_pkg::DIV_DW-1:0]       div_d;
  logic [tlik_pkg::DIV_QW-1:0]       div_q;
  logic                              cor_start, cor_done;
  logic signed [tlik_pkg::COR_IW-1:0] cor_y, cor_x;
  logic signed [tlik_pkg::COR_OW-1:0] cor_ang;

  // Combinational helpers
  logic [13:0]          xm, ym;
  logic signed [33:0]   num1_s;
  logic signed [29:0]   num2_s;
  logic [33:0]          mag1_w;
  logic [29:0]          mag2_w;
  logic                 reach_ok;
  logic signed [15:0]   c1_s, c2_s;
  logic signed [18:0]   sh_sum, el_sum;
  logic signed [SW-1:0] sh_ext, el_ext;
  logic signed [AW-1:0] sh_wrap, el_wrap;
  logic signed [DW-1:0] dsh_w, del_w;
  logic [DW-1:0]        dsh_mag, del_mag;
  logic [tlik_pkg::MUL_PW-1:0] deg_t;
  logic                 deg_sat;

  tlik_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a_in  (mul_a),
    .b_in  (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  tlik_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .v_in  (sq_v),
    .done  (sq_done),
    .root  (sq_root)
  );

  tlik_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .n_in  (div_n),
    .d_in  (div_d),
    .done  (div_done),
    .quot  (div_q)
  );

  tlik_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .y_in  (cor_y),
    .x_in  (cor_x),
    .done  (cor_done),
    .ang   (cor_ang)
  );

  // ---------------------------------------------------------------------------
  // Configuration port: writes land on the access phase, reads are direct.
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (tlik_pkg::reg_idx_t'(cfg_paddr[2]) == tlik_pkg::REG_L2) ?
                      32'(l2_r) : 32'(l1_r);

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlik_pkg::S_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      last_sh_r   <= '0;
      last_el_r   <= '0;
      l1_r        <= tlik_pkg::L1_RESET;
      l2_r        <= tlik_pkg::L2_RESET;
    end else begin
      state_r     <= state_nxt;
      go_r        <= (state_nxt != state_r);
      out_valid_r <= out_valid_nxt;
      last_sh_r   <= last_sh_nxt;
      last_el_r   <= last_el_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (tlik_pkg::reg_idx_t'(cfg_paddr[2]) == tlik_pkg::REG_L2) l2_r <= cfg_pwdata[12:0];
        else l1_r <= cfg_pwdata[12:0];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    r2_r    <= r2_nxt;
    l1sq_r  <= l1sq_nxt;
    l2sq_r  <= l2sq_nxt;
    r_r     <= r_nxt;
    den1_r  <= den1_nxt;
    den2_r  <= den2_nxt;
    mag1_r  <= mag1_nxt;
    mag2_r  <= mag2_nxt;
    neg1_r  <= neg1_nxt;
    neg2_r  <= neg2_nxt;
    cm1_r   <= cm1_nxt;
    cm2_r   <= cm2_nxt;
    s_r     <= s_nxt;
    acos1_r <= acos1_nxt;
    acos2_r <= acos2_nxt;
    atan_r  <= atan_nxt;
    dsh_r   <= dsh_nxt;
    del_r   <= del_nxt;
    shdeg_r <= shdeg_nxt;
    eldeg_r <= eldeg_nxt;
    unr_r   <= unr_nxt;
    osh_r   <= osh_nxt;
    oel_r   <= oel_nxt;
    ounr_r  <= ounr_nxt;
  end

  // ---------------------------------------------------------------------------
  // Datapath helpers
  // ---------------------------------------------------------------------------
  assign xm = x_r[13] ? 14'(-x_r) : 14'(x_r);
  assign ym = y_r[13] ? 14'(-y_r) : 14'(y_r);

  // acos numerators: law of cosines, the shoulder one scaled to match r in Q.12
  assign num1_s = (34'(l1sq_r) + 34'(r2_r) - 34'(l2sq_r)) <<< 4;
  assign num2_s = 30'(r2_r) - 30'(l1sq_r) - 30'(l2sq_r);
  assign mag1_w = num1_s[33] ? 34'(-num1_s) : 34'(num1_s);
  assign mag2_w = num2_s[29] ? 30'(-num2_s) : 30'(num2_s);
  assign reach_ok = (den1_r != '0) && (den2_r != '0) &&
                    (mag1_w <= 34'(den1_r)) && (mag2_w <= 30'(den2_r));

  assign c1_s = neg1_r ? -$signed({1'b0, cm1_r}) : $signed({1'b0, cm1_r});
  assign c2_s = neg2_r ? -$signed({1'b0, cm2_r}) : $signed({1'b0, cm2_r});

  // New angles, wrapped to the stored width, and their change
  assign sh_sum  = 19'(atan_r) + 19'(acos1_r);
  assign el_sum  = -19'(acos2_r);
  assign sh_ext  = SW'(sh_sum);
  assign el_ext  = SW'(el_sum);
  assign sh_wrap = sh_ext[AW-1:0];
  assign el_wrap = el_ext[AW-1:0];
  assign dsh_w   = DW'(sh_wrap) - DW'(last_sh_r);
  assign del_w   = DW'(el_wrap) - DW'(last_el_r);
  assign dsh_mag = dsh_r[DW-1] ? DW'(-dsh_r) : DW'(dsh_r);
  assign del_mag = del_r[DW-1] ? DW'(-del_r) : DW'(del_r);

  // Degree conversion: the multiplier holds |delta|*1260 once it is done
  assign deg_t   = mul_p + tlik_pkg::MUL_PW'(tlik_pkg::DEG_HALF);
  assign deg_sat = (deg_t >= tlik_pkg::MUL_PW'(tlik_pkg::DEG_SAT));

  // ---------------------------------------------------------------------------
  // Unit operand selection; each unit starts on the first cycle of its state
  // ---------------------------------------------------------------------------
  always_comb begin
    mul_start = 1'b0;
    sq_start  = 1'b0;
    div_start = 1'b0;
    cor_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    sq_v      = '0;
    div_n     = '0;
    div_d     = '0;
    cor_y     = '0;
    cor_x     = '0;
    unique case (state_r)
      tlik_pkg::S_MXX: begin
        mul_start = go_r;
        mul_a     = tlik_pkg::MUL_AW'(xm);
        mul_b     = tlik_pkg::MUL_BW'(xm);
      end
      tlik_pkg::S_MYY: begin
        mul_start = go_r;
        mul_a     = tlik_pkg::MUL_AW'(ym);
        mul_b     = tlik_pkg::MUL_BW'(ym);
      end
      tlik_pkg::S_ML1: begin
        mul_start = go_r;
        mul_a     = tlik_pkg::MUL_AW'(l1_r);
        mul_b     = tlik_pkg::MUL_BW'(l1_r);
      end
      tlik_pkg::S_ML2: begin
        mul_start = go_r;
        mul_a     = tlik_pkg::MUL_AW'(l2_r);
        mul_b     = tlik_pkg::MUL_BW'(l2_r);
      end
      tlik_pkg::S_SQR: begin
        sq_start = go_r;
        sq_v     = tlik_pkg::SQ_W'({r2_r, 8'd0});
      end
      tlik_pkg::S_MD1: begin
        mul_start = go_r;
        mul_a     = tlik_pkg::MUL_AW'(l1_r);
        mul_b     = tlik_pkg::MUL_BW'(r_r);
      end
      tlik_pkg::S_MD2: begin
        mul_start = go_r;
        mul_a     = tlik_pkg::MUL_AW'(l1_r);
        mul_b     = tlik_pkg::MUL_BW'(l2_r);
      end
      tlik_pkg::S_DV1: begin
        div_start = go_r;
        div_n     = (tlik_pkg::DIV_NW'(mag1_r) << 14) + tlik_pkg::DIV_NW'(den1_r >> 1);
        div_d     = tlik_pkg::DIV_DW'(den1_r);
      end
      tlik_pkg::S_DV2: begin
        div_start = go_r;
        div_n     = (tlik_pkg::DIV_NW'(mag2_r) << 14) + tlik_pkg::DIV_NW'(den2_r >> 1);
        div_d     = tlik_pkg::DIV_DW'(den2_r);
      end
      tlik_pkg::S_MC1: begin
        mul_start = go_r;
        mul_a     = tlik_pkg::MUL_AW'(cm1_r);
        mul_b     = tlik_pkg::MUL_BW'(cm1_r);
      end
      tlik_pkg::S_MC2: begin
        mul_start = go_r;
        mul_a     = tlik_pkg::MUL_AW'(cm2_r);
        mul_b     = tlik_pkg::MUL_BW'(cm2_r);
      end
      tlik_pkg::S_SQ1, tlik_pkg::S_SQ2: begin
        // sin from cos: sqrt(1 - c^2), the square still sits in the multiplier
        sq_start = go_r;
        sq_v     = tlik_pkg::SQ_W'(tlik_pkg::ONE_SQ_Q28 - mul_p[28:0]);
      end
      tlik_pkg::S_CO1: begin
        cor_start = go_r;
        cor_y     = $signed({1'b0, s_r});
        cor_x     = c1_s;
      end
      tlik_pkg::S_CO2: begin
        cor_start = go_r;
        cor_y     = $signed({1'b0, s_r});
        cor_x     = c2_s;
      end
      tlik_pkg::S_CO0: begin
        cor_start = go_r;
        cor_y     = tlik_pkg::COR_IW'(y_r);
        cor_x     = tlik_pkg::COR_IW'(x_r);
      end
      tlik_pkg::S_MG1: begin
        mul_start = go_r;
        mul_a     = tlik_pkg::MUL_AW'(dsh_mag);
        mul_b     = tlik_pkg::MUL_BW'(tlik_pkg::DEG_MUL);
      end
      tlik_pkg::S_MG2: begin
        mul_start = go_r;
        mul_a     = tlik_pkg::MUL_AW'(del_mag);
        mul_b     = tlik_pkg::MUL_BW'(tlik_pkg::DEG_MUL);
      end
      tlik_pkg::S_DG1, tlik_pkg::S_DG2: begin
        div_start = go_r;
        div_n     = deg_t[tlik_pkg::DIV_NW-1:0];
        div_d     = tlik_pkg::DIV_DW'(tlik_pkg::DEG_DIV);
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state and register updates
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    last_sh_nxt   = last_sh_r;
    last_el_nxt   = last_el_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    r2_nxt    = r2_r;
    l1sq_nxt  = l1sq_r;
    l2sq_nxt  = l2sq_r;
    r_nxt     = r_r;
    den1_nxt  = den1_r;
    den2_nxt  = den2_r;
    mag1_nxt  = mag1_r;
    mag2_nxt  = mag2_r;
    neg1_nxt  = neg1_r;
    neg2_nxt  = neg2_r;
    cm1_nxt   = cm1_r;
    cm2_nxt   = cm2_r;
    s_nxt     = s_r;
    acos1_nxt = acos1_r;
    acos2_nxt = acos2_r;
    atan_nxt  = atan_r;
    dsh_nxt   = dsh_r;
    del_nxt   = del_r;
    shdeg_nxt = shdeg_r;
    eldeg_nxt = eldeg_r;
    unr_nxt   = unr_r;
    osh_nxt   = osh_r;
    oel_nxt   = oel_r;
    ounr_nxt  = ounr_r;

    in_ready = (state_r == tlik_pkg::S_IDLE);

    // drop the result once it is taken
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      tlik_pkg::S_IDLE: begin
        if (in_valid) begin
          x_nxt     = in_target_x;
          y_nxt     = in_target_y;
          state_nxt = tlik_pkg::S_MXX;
        end
      end
      tlik_pkg::S_MXX: begin
        if (mul_done) begin
          r2_nxt    = mul_p[27:0];
          state_nxt = tlik_pkg::S_MYY;
        end
      end
      tlik_pkg::S_MYY: begin
        if (mul_done) begin
          r2_nxt    = r2_r + mul_p[27:0];
          state_nxt = tlik_pkg::S_ML1;
        end
      end
      tlik_pkg::S_ML1: begin
        if (mul_done) begin
          l1sq_nxt  = mul_p[25:0];
          state_nxt = tlik_pkg::S_ML2;
        end
      end
      tlik_pkg::S_ML2: begin
        if (mul_done) begin
          l2sq_nxt  = mul_p[25:0];
          state_nxt = tlik_pkg::S_SQR;
        end
      end
      tlik_pkg::S_SQR: begin
        if (sq_done) begin
          r_nxt     = sq_root;
          state_nxt = tlik_pkg::S_MD1;
        end
      end
      tlik_pkg::S_MD1: begin
        if (mul_done) begin
          den1_nxt  = {mul_p[31:0], 1'b0};
          state_nxt = tlik_pkg::S_MD2;
        end
      end
      tlik_pkg::S_MD2: begin
        if (mul_done) begin
          den2_nxt  = {mul_p[25:0], 1'b0};
          state_nxt = tlik_pkg::S_CHK;
        end
      end
      tlik_pkg::S_CHK: begin
        mag1_nxt = mag1_w[32:0];
        mag2_nxt = mag2_w[28:0];
        neg1_nxt = num1_s[33];
        neg2_nxt = num2_s[29];
        if (reach_ok) begin
          state_nxt = tlik_pkg::S_DV1;
        end else begin
          // out of reach: zero deltas, angles untouched
          shdeg_nxt = '0;
          eldeg_nxt = '0;
          unr_nxt   = 1'b1;
          state_nxt = tlik_pkg::S_DONE;
        end
      end
      tlik_pkg::S_DV1: begin
        if (div_done) begin
          cm1_nxt   = div_q;
          state_nxt = tlik_pkg::S_DV2;
        end
      end
      tlik_pkg::S_DV2: begin
        if (div_done) begin
          cm2_nxt   = div_q;
          state_nxt = tlik_pkg::S_MC1;
        end
      end
      tlik_pkg::S_MC1: begin
        if (mul_done) state_nxt = tlik_pkg::S_SQ1;
      end
      tlik_pkg::S_SQ1: begin
        if (sq_done) begin
          s_nxt     = sq_root[14:0];
          state_nxt = tlik_pkg::S_CO1;
        end
      end
      tlik_pkg::S_CO1: begin
        if (cor_done) begin
          acos1_nxt = cor_ang;
          state_nxt = tlik_pkg::S_MC2;
        end
      end
      tlik_pkg::S_MC2: begin
        if (mul_done) state_nxt = tlik_pkg::S_SQ2;
      end
      tlik_pkg::S_SQ2: begin
        if (sq_done) begin
          s_nxt     = sq_root[14:0];
          state_nxt = tlik_pkg::S_CO2;
        end
      end
      tlik_pkg::S_CO2: begin
        if (cor_done) begin
          acos2_nxt = cor_ang;
          state_nxt = tlik_pkg::S_CO0;
        end
      end
      tlik_pkg::S_CO0: begin
        if (cor_done) begin
          atan_nxt  = cor_ang;
          state_nxt = tlik_pkg::S_ANG;
        end
      end
      tlik_pkg::S_ANG: begin
        dsh_nxt     = dsh_w;
        del_nxt     = del_w;
        last_sh_nxt = sh_wrap;
        last_el_nxt = el_wrap;
        state_nxt   = tlik_pkg::S_MG1;
      end
      tlik_pkg::S_MG1: begin
        if (mul_done) begin
          if (deg_sat) begin
            shdeg_nxt = dsh_r[DW-1] ? 11'sh400 : 11'sh3FF;
            state_nxt = tlik_pkg::S_MG2;
          end else begin
            state_nxt = tlik_pkg::S_DG1;
          end
        end
      end
      tlik_pkg::S_DG1: begin
        if (div_done) begin
          shdeg_nxt = dsh_r[DW-1] ? 11'(-div_q[10:0]) : 11'(div_q[10:0]);
          state_nxt = tlik_pkg::S_MG2;
        end
      end
      tlik_pkg::S_MG2: begin
        if (mul_done) begin
          unr_nxt = 1'b0;
          if (deg_sat) begin
            eldeg_nxt = del_r[DW-1] ? 11'sh400 : 11'sh3FF;
            state_nxt = tlik_pkg::S_DONE;
          end else begin
            state_nxt = tlik_pkg::S_DG2;
          end
        end
      end
      tlik_pkg::S_DG2: begin
        if (div_done) begin
          eldeg_nxt = del_r[DW-1] ? 11'(-div_q[10:0]) : 11'(div_q[10:0]);
          state_nxt = tlik_pkg::S_DONE;
        end
      end
      tlik_pkg::S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          osh_nxt       = shdeg_r;
          oel_nxt       = eldeg_r;
          ounr_nxt      = unr_r;
          out_valid_nxt = 1'b1;
          state_nxt     = tlik_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tlik_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid              = out_valid_r;
  assign out_shoulder_delta_deg = osh_r;
  assign out_elbow_delta_deg    = oel_r;
  assign out_unreachable        = ounr_r;

endmodule

// File: tb/sv/tlik_checker.sv
`timescale 1ns / 1ps
// Checker for the two-link inverse kinematics core: predicts each result and compares.
module tlik_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [13:0] in_target_x,
  input  logic signed [13:0] in_target_y,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [10:0] out_shoulder_delta_deg,
  input  logic signed [10:0] out_elbow_delta_deg,
  input  logic               out_unreachable,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  input  logic               cfg_pready,
  output int                 pending,
  output int                 fail_count,
  output int                 checked_count,
  output int                 unreach_count
);

  localparam int ANG_W  = tlik_pkg::ANGLE_WIDTH_DEF;
  localparam int STEPS  = tlik_pkg::CORDIC_STEPS_DEF;
  localparam longint QUARTER_Q20 = 1647099;

  typedef struct packed {
    logic signed [10:0] shoulder;
    logic signed [10:0] elbow;
    logic               unreach;
  } ik_result_t;

  ik_result_t   expected_q[$];
  logic [12:0]  link1, link2;
  longint       prev_shoulder, prev_elbow;

  longint arctan_q20 [24] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
    8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0};

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint vec_atan2(longint y, longint x);
    longint px, py, z, t;
    px = x * 16384;
    py = y * 16384;
    z = 0;
    if (px < 0) begin
      if (py >= 0) begin
        t = px; px = py; py = -t; z = QUARTER_Q20;
      end else begin
        t = px; px = -py; py = t; z = -QUARTER_Q20;
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      if (py >= 0) begin
        t = px + (py >>> i); py = py - (px >>> i); px = t; z += arctan_q20[i];
      end else begin
        t = px - (py >>> i); py = py + (px >>> i); px = t; z -= arctan_q20[i];
      end
    end
    return (z + 32) >>> 6;
  endfunction

  // Q.14 cosine argument; false when den is zero or |num| exceeds den
  function automatic bit cos_ratio(longint num, longint den, output longint c);
    longint unsigned mag, q;
    mag = (num < 0) ? -num : num;
    c = 0;
    if (den == 0 || mag > den) return 0;
    q = ((mag << 14) + (den >> 1)) / den;
    c = (num < 0) ? -longint'(q) : longint'(q);
    return 1;
  endfunction

  function automatic longint arc_cos(longint c);
    return vec_atan2(longint'(int_sqrt(16384 * 16384 - c * c)), c);
  endfunction

  function automatic longint wrap_ang(longint v);
    return (v <<< (64 - ANG_W)) >>> (64 - ANG_W);
  endfunction

  function automatic logic signed [10:0] rad_to_deg(longint d);
    longint unsigned mag, q;
    longint v;
    mag = (d < 0) ? -d : d;
    q = (mag * 1260 + 11 * 16384) / (22 * 16384);
    if (q > 1024) q = 1024;
    v = (d < 0) ? -longint'(q) : longint'(q);
    if (v > 1023) v = 1023;
    return v[10:0];
  endfunction

  always @(posedge clk) begin
    ik_result_t exp_r, got;
    longint x, y, l1, l2, r2, r, c1, c2, sh, el;
    bit ok;
    if (!rst_n) begin
      expected_q.delete();
      link1 <= tlik_pkg::L1_RESET;
      link2 <= tlik_pkg::L2_RESET;
      prev_shoulder = 0;
      prev_elbow = 0;
      fail_count <= 0;
      checked_count <= 0;
      unreach_count <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (tlik_pkg::reg_idx_t'(cfg_paddr[2]) == tlik_pkg::REG_L1) link1 <= cfg_pwdata[12:0];
        else link2 <= cfg_pwdata[12:0];
      end
      if (in_valid && in_ready) begin
        x = in_target_x;
        y = in_target_y;
        l1 = link1;
        l2 = link2;
        r2 = x * x + y * y;
        r = int_sqrt(r2 << 8);
        ok = (r != 0);
        if (ok) ok = cos_ratio((l1 * l1 + r2 - l2 * l2) * 16, 2 * l1 * r, c1);
        if (ok) ok = cos_ratio(r2 - l1 * l1 - l2 * l2, 2 * l1 * l2, c2);
        if (!ok) begin
          exp_r = '{shoulder: '0, elbow: '0, unreach: 1'b1};
        end else begin
          sh = wrap_ang(vec_atan2(y, x) + arc_cos(c1));
          el = wrap_ang(-arc_cos(c2));
          exp_r = '{shoulder: rad_to_deg(sh - prev_shoulder),
                    elbow: rad_to_deg(el - prev_elbow), unreach: 1'b0};
          prev_shoulder = sh;
          prev_elbow = el;
        end
        expected_q.push_back(exp_r);
      end
      if (out_valid && out_ready) begin
        got = '{out_shoulder_delta_deg, out_elbow_delta_deg, out_unreachable};
        checked_count <= checked_count + 1;
        if (got.unreach) unreach_count <= unreach_count + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected: sh=%0d el=%0d unr=%0b",
                   $time, got.shoulder, got.elbow, got.unreach);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch expected sh=%0d el=%0d unr=%0b, actual sh=%0d el=%0d unr=%0b",
                     $time, exp_r.shoulder, exp_r.elbow, exp_r.unreach,
                     got.shoulder, got.elbow, got.unreach);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

// File: tb/sv/tb_two_link_inverse_kinematics_core.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the two-link inverse kinematics core.
module tb_two_link_inverse_kinematics_core;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 500;   // a little over the slowest request

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [13:0] in_target_x = '0;
  logic signed [13:0] in_target_y = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [10:0] out_shoulder_delta_deg;
  logic signed [10:0] out_elbow_delta_deg;
  logic               out_unreachable;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [2:0]         cfg_paddr = '0;
  logic [31:0]        cfg_pwdata = '0;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  int  pending, fail_count, checked_count, unreach_count;
  int  cycle_count = 0;
  int  requests_sent = 0;
  bit  no_gaps = 0;          // stretches where neither side idles
  int  cur_l1 = tlik_pkg::L1_RESET, cur_l2 = tlik_pkg::L2_RESET;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  two_link_inverse_kinematics_core i_dut (.*);

  tlik_checker i_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_target_x, .in_target_y,
    .out_valid, .out_ready, .out_shoulder_delta_deg, .out_elbow_delta_deg,
    .out_unreachable, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_pready, .pending, .fail_count, .checked_count, .unreach_count
  );

  // Timeout watchdog: count cycles and give up well past the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_two_link_inverse_kinematics_core: errors");
      $finish;
    end
  end

  // Result side: stall for a random gap before each result, then hold ready
  // high until a result is taken
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  // Issue one request: idle a random gap, then hold valid and payload until taken
  task automatic send_target(input int x, input int y);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_target_x <= x[13:0];
    in_target_y <= y[13:0];
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
    requests_sent++;
  endtask

  // Drop valid and hold off until every expected result is back, then settle
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Write (setup phase, then access phase) to one link length register
  task automatic write_link(input tlik_pkg::reg_idx_t idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == tlik_pkg::REG_L1) cur_l1 = value[12:0];
    else cur_l2 = value[12:0];
  endtask

  function automatic int clamp14(real v);
    int i;
    i = $rtoi(v < 0.0 ? v - 0.5 : v + 0.5);
    if (i > 8191) i = 8191;
    if (i < -8192) i = -8192;
    return i;
  endfunction

  // Mostly targets inside the reachable annulus, the rest raw noise
  task automatic random_phase(input int n);
    real rmin, rmax, rad, ang;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) < 8) begin
        rmin = (cur_l1 > cur_l2) ? cur_l1 - cur_l2 : cur_l2 - cur_l1;
        rmax = cur_l1 + cur_l2;
        rad  = rmin + (rmax - rmin) * ($urandom_range(0, 100000) / 100000.0);
        ang  = 6.283185307 * ($urandom_range(0, 100000) / 100000.0);
        send_target(clamp14(rad * $cos(ang)), clamp14(rad * $sin(ang)));
      end else begin
        send_target($signed($urandom_range(0, 16383) - 8192),
                    $signed($urandom_range(0, 16383) - 8192));
      end
      // toggle back-to-back stretches now and then
      if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: field extremes, zero radius, negative-x pre-rotation, reach edges
    send_target(0, 0);
    send_target(8191, 8191);
    send_target(-8192, -8192);
    send_target(-8192, 8191);
    send_target(8191, -8192);
    send_target(4992, 0);
    send_target(0, 4992);
    send_target(-4992, 0);
    send_target(0, -4992);
    send_target(128, 0);
    send_target(100, 0);
    send_target(3000, 2000);
    send_target(-3000, 2000);
    send_target(-3000, -2000);
    send_target(3000, -2000);
    send_target(1, 0);
    send_target(-1, -1);
    send_target(4991, 1);
    drain();

    random_phase(150);
    drain();

    // Longest links, junk in upper data bits
    write_link(tlik_pkg::REG_L1, 32'hFFFF_FFFF);
    write_link(tlik_pkg::REG_L2, 32'h0000_1FFF);
    send_target(8191, 8191);
    send_target(-8192, 0);
    random_phase(130);
    drain();

    // Shortest links: only points within a couple of LSBs reach
    write_link(tlik_pkg::REG_L1, 32'd1);
    write_link(tlik_pkg::REG_L2, 32'd1);
    send_target(2, 0);
    send_target(0, -2);
    send_target(1, 1);
    send_target(3, 0);
    random_phase(100);
    drain();

    // Uneven links
    write_link(tlik_pkg::REG_L1, 32'd3000);
    write_link(tlik_pkg::REG_L2, 32'd1200);
    random_phase(150);
    drain();

    write_link(tlik_pkg::REG_L1, 32'd700);
    write_link(tlik_pkg::REG_L2, 32'd6500);
    random_phase(120);
    drain();

    // Zero link length: every target must come back unreachable
    write_link(tlik_pkg::REG_L1, 32'd0);
    random_phase(20);
    drain();
    write_link(tlik_pkg::REG_L1, 32'd2432);
    write_link(tlik_pkg::REG_L2, 32'd0);
    random_phase(20);
    drain();

    write_link(tlik_pkg::REG_L1, $urandom_range(1, 8191));
    write_link(tlik_pkg::REG_L2, $urandom_range(1, 8191));
    random_phase(150);
    drain();

    $display("sent %0d targets over 8 link settings; %0d results checked, %0d unreachable",
             requests_sent, checked_count, unreach_count);
    if (fail_count == 0) begin
      $display("tb_two_link_inverse_kinematics_core: clean");
    end else begin
      $display("tb_two_link_inverse_kinematics_core: errors");
    end
    $finish;
  end

endmodule
